// ===== rtl/hpr_pkg.sv =====
package hpr_pkg;

  // pipeline geometry
  localparam int unsigned NumStages   = 12;
  localparam int unsigned CordicSteps = 8;

  // datapath widths
  localparam int unsigned ErrW  = 34;
  localparam int unsigned WW    = 43;
  localparam int unsigned CsW   = 20;
  localparam int unsigned ZW    = 26;

  localparam logic signed [CsW-1:0] CordicStart = 20'sd39797;
  localparam logic signed [19:0]    TwoPiQ16    = 20'sd411775;

  // arctangent of 2^-i in 2^-24 turn
  localparam logic signed [ZW-1:0] AtanTurns [16] = '{
    26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050,
    26'sd166669,  26'sd83416,   26'sd41718,  26'sd20860,
    26'sd10430,   26'sd5215,    26'sd2608,   26'sd1304,
    26'sd652,     26'sd326,     26'sd163,    26'sd81
  };

  // register map
  typedef enum logic [2:0] {
    RegGoalX       = 3'd0,
    RegGoalY       = 3'd1,
    RegGoalHeading = 3'd2,
    RegGainX       = 3'd3,
    RegGainY       = 3'd4,
    RegGainHeading = 3'd5,
    RegMaxSpeed    = 3'd6,
    RegMaxTurnRate = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] gain_x;
    logic [15:0] gain_y;
    logic [15:0] gain_heading;
    logic [14:0] max_speed;
    logic [14:0] max_turn_rate;
  } gain_cfg_t;

  typedef struct packed {
    logic signed [CsW-1:0] x;
    logic signed [CsW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cordic_t;

  // one micro-rotation
  function automatic cordic_t cordic_iter(cordic_t a, logic [3:0] i);
    cordic_t r;
    if (!a.z[ZW-1]) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - AtanTurns[i];
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + AtanTurns[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/hpr_cordic.sv =====
module hpr_cordic (
  input  logic                                    clk_i,
  input  logic [hpr_pkg::CordicSteps-1:0]         en_i,
  input  logic signed [hpr_pkg::ZW-1:0]           z0_i,
  output logic signed [hpr_pkg::CsW-1:0]          cos_o,
  output logic signed [hpr_pkg::CsW-1:0]          sin_o
);
  import hpr_pkg::*;

  cordic_t st_q [CordicSteps];
  cordic_t init;

  assign init = '{x: CordicStart, y: '0, z: z0_i};

  // two micro-rotations per register stage
  for (genvar j = 0; j < CordicSteps; j++) begin : g_step
    cordic_t prev;
    if (j == 0) begin : g_first
      assign prev = init;
    end else begin : g_next
      assign prev = st_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        st_q[j] <= cordic_iter(cordic_iter(prev, 4'(2*j)), 4'(2*j+1));
      end
    end
  end

  assign cos_o = st_q[CordicSteps-1].x;
  assign sin_o = st_q[CordicSteps-1].y;

endmodule

// ===== rtl/hpr_gain.sv =====
module hpr_gain #(
  parameter int unsigned NEAR_DIST  = 6554,
  parameter int unsigned NEAR_ANGLE = 1043
) (
  input  logic                               clk_i,
  input  logic [hpr_pkg::CordicSteps-1:0]    en_i,
  input  hpr_pkg::gain_cfg_t                 cfg_i,
  input  logic signed [hpr_pkg::ErrW-1:0]    ex_i,
  input  logic signed [hpr_pkg::ErrW-1:0]    ey_i,
  input  logic signed [15:0]                 beta_i,
  input  logic                               flip_i,
  output logic signed [hpr_pkg::WW-1:0]      wx_o,
  output logic signed [hpr_pkg::WW-1:0]      wy_o,
  output logic signed [15:0]                 turn_o,
  output logic                               done_o
);
  import hpr_pkg::*;

  localparam logic signed [ErrW-1:0] NearLim = 34'sd2147483648;
  localparam logic [63:0] ThrSq = 64'(NEAR_DIST) * 64'(NEAR_DIST);
  localparam int unsigned DlyN = CordicSteps - 3;

  typedef struct packed {
    logic signed [WW-1:0] wx;
    logic signed [WW-1:0] wy;
    logic signed [15:0]   turn;
    logic                 done;
  } gout_t;

  // stage one: gains, magnitudes
  logic signed [50:0] pxw_d, pxw_q, pyw_d, pyw_q;
  logic signed [32:0] bg_d, bg_q;
  logic [30:0]        ax_d, ax_q, ay_d, ay_q;
  logic               near_d, near_q, angok_d, angok_q, flip1_q;
  logic signed [ErrW-1:0] abx, aby;
  logic signed [16:0] ab;

  always_comb begin
    pxw_d  = ex_i * $signed({1'b0, cfg_i.gain_x});
    pyw_d  = ey_i * $signed({1'b0, cfg_i.gain_y});
    bg_d   = beta_i * $signed({1'b0, cfg_i.gain_heading});
    abx    = ex_i[ErrW-1] ? -ex_i : ex_i;
    aby    = ey_i[ErrW-1] ? -ey_i : ey_i;
    near_d = (ex_i > -NearLim) && (ex_i < NearLim) && (ey_i > -NearLim) && (ey_i < NearLim);
    ax_d   = near_d ? abx[30:0] : '0;
    ay_d   = near_d ? aby[30:0] : '0;
    ab     = beta_i[15] ? -{beta_i[15], beta_i} : {beta_i[15], beta_i};
    angok_d = ab < $signed(17'(NEAR_ANGLE));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pxw_q <= pxw_d; pyw_q <= pyw_d; bg_q <= bg_d;
      ax_q <= ax_d; ay_q <= ay_d;
      near_q <= near_d; angok_q <= angok_d; flip1_q <= flip_i;
    end
  end

  // stage two: shift, fold sign, squares, turn product
  logic signed [WW-1:0] wx2, wy2, wxf_q, wyf_q;
  logic signed [52:0]   tp_d, tp_q;
  logic [61:0]          ax2_q, ay2_q;
  logic                 near2_q, angok2_q;

  assign wx2  = pxw_q[50:8];
  assign wy2  = pyw_q[50:8];
  assign tp_d = bg_q * TwoPiQ16;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      wxf_q <= flip1_q ? -wx2 : wx2;
      wyf_q <= flip1_q ? -wy2 : wy2;
      tp_q  <= tp_d;
      ax2_q <= 62'(ax_q) * 62'(ax_q);
      ay2_q <= 62'(ay_q) * 62'(ay_q);
      near2_q <= near_q; angok2_q <= angok_q;
    end
  end

  // stage three: distance compare, turn clamp
  logic [62:0]        dsum;
  logic signed [20:0] tsh, tlim, tcl;
  gout_t              g3_d;
  gout_t              dly_q [DlyN+1];

  always_comb begin
    dsum = 63'(ax2_q) + 63'(ay2_q);
    tsh  = tp_q[52:32];
    tlim = $signed({6'b0, cfg_i.max_turn_rate});
    if (tsh > tlim) begin
      tcl = tlim;
    end else if (tsh < -tlim) begin
      tcl = -tlim;
    end else begin
      tcl = tsh;
    end
    g3_d.wx   = wxf_q;
    g3_d.wy   = wyf_q;
    g3_d.turn = tcl[15:0];
    g3_d.done = near2_q && angok2_q && ({1'b0, dsum} < ThrSq);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dly_q[0] <= g3_d;
    end
  end

  // alignment with the rotator
  for (genvar k = 1; k <= DlyN; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i[2+k]) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  assign wx_o   = dly_q[DlyN].wx;
  assign wy_o   = dly_q[DlyN].wy;
  assign turn_o = dly_q[DlyN].turn;
  assign done_o = dly_q[DlyN].done;

endmodule

// ===== rtl/hpr_rot.sv =====
module hpr_rot (
  input  logic                            clk_i,
  input  logic [2:0]                      en_i,
  input  logic [14:0]                     max_speed_i,
  input  logic signed [hpr_pkg::WW-1:0]   wx_i,
  input  logic signed [hpr_pkg::WW-1:0]   wy_i,
  input  logic signed [hpr_pkg::CsW-1:0]  cos_i,
  input  logic signed [hpr_pkg::CsW-1:0]  sin_i,
  input  logic signed [15:0]              turn_i,
  input  logic                            done_i,
  output logic signed [15:0]              vel_x_o,
  output logic signed [15:0]              vel_y_o,
  output logic signed [15:0]              turn_o,
  output logic                            done_o
);
  import hpr_pkg::*;

  localparam int unsigned PW = WW + CsW;

  // products
  logic signed [PW-1:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [15:0]   t1_q, t2_q;
  logic                 d1_q, d2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pxc_q <= wx_i * cos_i;
      pys_q <= wy_i * sin_i;
      pyc_q <= wy_i * cos_i;
      pxs_q <= wx_i * sin_i;
      t1_q  <= turn_i;
      d1_q  <= done_i;
    end
  end

  // sums and scaling
  logic signed [63:0] sx, sy;
  logic signed [39:0] sx_q, sy_q;

  assign sx = 64'(pxc_q) + 64'(pys_q);
  assign sy = 64'(pyc_q) - 64'(pxs_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sx_q <= sx[63:24];
      sy_q <= sy[63:24];
      t2_q <= t1_q;
      d2_q <= d1_q;
    end
  end

  // symmetric clamp into the output register
  logic signed [39:0] lim;
  logic signed [39:0] cx, cy;

  always_comb begin
    lim = $signed({25'b0, max_speed_i});
    if (sx_q > lim) begin
      cx = lim;
    end else if (sx_q < -lim) begin
      cx = -lim;
    end else begin
      cx = sx_q;
    end
    if (sy_q > lim) begin
      cy = lim;
    end else if (sy_q < -lim) begin
      cy = -lim;
    end else begin
      cy = sy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      vel_x_o <= cx[15:0];
      vel_y_o <= cy[15:0];
      turn_o  <= t2_q;
      done_o  <= d2_q;
    end
  end

endmodule

// ===== rtl/holonomic_pose_regulator.sv =====
// channel   | signals                                          | direction
// ----------+--------------------------------------------------+----------
// pose in   | in_valid_i in_ready_o pose_x/y/heading_i run_start_i | in
// command   | out_valid_o out_ready_i vel_x/y_o turn_rate_o done_res_o | out
// config    | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i   | in
//
// one pose per cycle while the output is not stalled, through twelve register stages
// the stages are the capture stage, 8 cordic stages (two rotations each),
// and three stages of product, sum and clamp
// each stage holds its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up and a stalled output holds its result
// reset clears valid bits and the origin and sets the config registers to their reset values
module holonomic_pose_regulator #(
  parameter int unsigned NEAR_DIST     = 6554,
  parameter int unsigned NEAR_ANGLE    = 1043,
  parameter bit          RELATIVE_MODE = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pose_x_i,
  input  logic signed [31:0] pose_y_i,
  input  logic signed [15:0] pose_heading_i,
  input  logic               run_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] vel_x_o,
  output logic signed [15:0] vel_y_o,
  output logic signed [15:0] turn_rate_o,
  output logic               done_res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import hpr_pkg::*;

  // configuration registers
  logic signed [31:0] goal_x_q, goal_y_q;
  logic signed [15:0] goal_h_q;
  gain_cfg_t          cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      goal_h_q <= '0;
      cfg_q    <= '{gain_x: 16'd256, gain_y: 16'd256, gain_heading: 16'd256,
                    max_speed: 15'd256, max_turn_rate: 15'd256};
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegGoalX:       goal_x_q <= cfg_data_i;
        RegGoalY:       goal_y_q <= cfg_data_i;
        RegGoalHeading: goal_h_q <= cfg_data_i[15:0];
        RegGainX:       cfg_q.gain_x <= cfg_data_i[15:0];
        RegGainY:       cfg_q.gain_y <= cfg_data_i[15:0];
        RegGainHeading: cfg_q.gain_heading <= cfg_data_i[15:0];
        RegMaxSpeed:    cfg_q.max_speed <= cfg_data_i[14:0];
        RegMaxTurnRate: cfg_q.max_turn_rate <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic [NumStages-1:0] v_q, en;
  logic                 accept;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign accept      = in_valid_i && en[0];
  assign out_valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // origin latch for relative runs
  logic signed [31:0] org_x_q, org_y_q, org_x, org_y;
  logic signed [15:0] org_h_q, org_h;
  logic               latch;

  assign latch = RELATIVE_MODE && run_start_i;
  assign org_x = latch ? pose_x_i : org_x_q;
  assign org_y = latch ? pose_y_i : org_y_q;
  assign org_h = latch ? pose_heading_i : org_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_h_q <= '0;
    end else if (accept && latch) begin
      org_x_q <= pose_x_i;
      org_y_q <= pose_y_i;
      org_h_q <= pose_heading_i;
    end
  end

  // capture stage: errors and heading fold
  logic signed [ErrW-1:0] ex_d, ey_d, ex_q, ey_q;
  logic signed [15:0]     beta_q;
  logic signed [16:0]     hs, hf;
  logic                   flip_d, flip_q;
  logic signed [ZW-1:0]   z0_q;

  always_comb begin
    ex_d = ErrW'(goal_x_q) + ErrW'(org_x) - ErrW'(pose_x_i);
    ey_d = ErrW'(goal_y_q) + ErrW'(org_y) - ErrW'(pose_y_i);
    hs   = 17'(pose_heading_i);
    if (hs > 17'sd16384) begin
      hf = hs - 17'sd32768; flip_d = 1'b1;
    end else if (hs < -17'sd16384) begin
      hf = hs + 17'sd32768; flip_d = 1'b1;
    end else begin
      hf = hs; flip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      beta_q <= goal_h_q + org_h - pose_heading_i;
      flip_q <= flip_d;
      z0_q   <= {hf[16], hf, 8'b0};
    end
  end

  logic signed [CsW-1:0] cos_w, sin_w;
  logic signed [WW-1:0]  wx_w, wy_w;
  logic signed [15:0]    turn_w;
  logic                  done_w;

  hpr_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en[CordicSteps:1]),
    .z0_i  (z0_q),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  hpr_gain #(
    .NEAR_DIST  (NEAR_DIST),
    .NEAR_ANGLE (NEAR_ANGLE)
  ) u_gain (
    .clk_i  (clk_i),
    .en_i   (en[CordicSteps:1]),
    .cfg_i  (cfg_q),
    .ex_i   (ex_q),
    .ey_i   (ey_q),
    .beta_i (beta_q),
    .flip_i (flip_q),
    .wx_o   (wx_w),
    .wy_o   (wy_w),
    .turn_o (turn_w),
    .done_o (done_w)
  );

  hpr_rot u_rot (
    .clk_i       (clk_i),
    .en_i        (en[NumStages-1:CordicSteps+1]),
    .max_speed_i (cfg_q.max_speed),
    .wx_i        (wx_w),
    .wy_i        (wy_w),
    .cos_i       (cos_w),
    .sin_i       (sin_w),
    .turn_i      (turn_w),
    .done_i      (done_w),
    .vel_x_o     (vel_x_o),
    .vel_y_o     (vel_y_o),
    .turn_o      (turn_rate_o),
    .done_o      (done_res_o)
  );

endmodule

// ===== rtl/hpr_chk.sv =====
module hpr_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] vel_x_o,
  input logic signed [15:0] vel_y_o,
  input logic signed [15:0] turn_rate_o
);

  // a stalled command stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("command dropped while stalled");

  // clamps are symmetric, so the most negative code never appears
  a_vx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vel_x_o != 16'sh8000)
    else $error("vel_x outside clamp");

  a_vy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vel_y_o != 16'sh8000)
    else $error("vel_y outside clamp");

  a_tr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> turn_rate_o != 16'sh8000)
    else $error("turn_rate outside clamp");

endmodule

bind holonomic_pose_regulator hpr_chk u_hpr_chk (.*);
